// ----- src/pidl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

  localparam int LOC_W   = 6;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Broadcast to every cell in the row for one transaction.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic [LOC_W-1:0]         loc;
    logic signed [DATA_W-1:0] value;
  } shift_ctrl_t;

endpackage

`default_nettype wire

// ----- src/positional_insert_delete_list_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// command   in         start & !busy          op, location, value
// result    out        done (one cycle)       ok, read_value, count
//
// Each transaction is handled by the row of cells, which shifts all entries in
// parallel at the accepting edge, and the result appears on the next cycle
// with done high for exactly that cycle. busy is never raised, so a new
// command can be accepted in every cycle. rst is synchronous and clears the
// element count and done; entry contents are not cleared. The receiver
// cannot stall results.

module positional_insert_delete_list_top #(
  parameter int CAPACITY = 64
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  output logic                                    busy,
  input  wire logic [pidl_pkg::OP_W-1:0]          op,
  input  wire logic [pidl_pkg::LOC_W-1:0]         location,
  input  wire logic signed [pidl_pkg::DATA_W-1:0] value,
  output logic                                    done,
  output logic                                    ok,
  output logic signed [pidl_pkg::DATA_W-1:0]      read_value,
  output logic [pidl_pkg::COUNT_W-1:0]            count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = ($clog2(CAPACITY) > pidl_pkg::LOC_W) ?
                         $clog2(CAPACITY) : pidl_pkg::LOC_W;
  localparam int CMP_W = (CNT_W > pidl_pkg::LOC_W) ? CNT_W : pidl_pkg::LOC_W;
  localparam logic [CNT_W-1:0] CAP_VAL = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              accept;
  logic [CMP_W-1:0]  loc_cmp;
  logic [CMP_W-1:0]  cnt_cmp;
  logic              ins_ok;
  logic              get_ok;
  logic              del_ok;
  logic              op_ok;
  logic signed [pidl_pkg::DATA_W-1:0] rd_or;
  pidl_pkg::shift_ctrl_t ctrl;

  logic signed [pidl_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic signed [pidl_pkg::DATA_W-1:0] cell_rd   [CAPACITY];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign loc_cmp = CMP_W'(location);
  assign cnt_cmp = CMP_W'(cnt);

  always_comb begin
    ins_ok = 1'b0;
    get_ok = 1'b0;
    del_ok = 1'b0;
    unique case (op)
      pidl_pkg::OP_INSERT: ins_ok = (loc_cmp <= cnt_cmp) && (cnt < CAP_VAL);
      pidl_pkg::OP_GET:    get_ok = (loc_cmp < cnt_cmp);
      pidl_pkg::OP_DELETE: del_ok = (loc_cmp < cnt_cmp);
      default: ;
    endcase
  end

  assign op_ok = ins_ok || get_ok || del_ok;

  assign ctrl.ins   = accept && ins_ok;
  assign ctrl.del   = accept && del_ok;
  assign ctrl.loc   = location;
  assign ctrl.value = value;

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [pidl_pkg::DATA_W-1:0] left_d;
      logic signed [pidl_pkg::DATA_W-1:0] right_d;
      if (gi == 0) begin : g_first
        assign left_d = value;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      pidl_cell #(
        .IDX_W   (IDX_W),
        .CELL_IDX(gi)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .left_data (left_d),
        .right_data(right_d),
        .data      (cell_data[gi]),
        .rd_data   (cell_rd[gi])
      );
    end
  endgenerate

  // Only the addressed cell drives a nonzero read word.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok         <= op_ok;
      read_value <= get_ok ? rd_or : '0;
      count      <= pidl_pkg::COUNT_W'(cnt_next);
    end
  end

endmodule

`default_nettype wire

// ----- src/pidl_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidl_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire                                  clk,
  input  wire pidl_pkg::shift_ctrl_t           ctrl,
  input  wire logic signed [pidl_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [pidl_pkg::DATA_W-1:0] right_data,
  output logic signed [pidl_pkg::DATA_W-1:0]  data,
  output logic signed [pidl_pkg::DATA_W-1:0]  rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [IDX_W-1:0] loc_ext;
  logic             hit;
  logic             above;

  assign loc_ext = IDX_W'(ctrl.loc);
  assign hit     = (MY_IDX == loc_ext);
  assign above   = (MY_IDX > loc_ext);

  // Cells past the insert point take their left neighbor; from the delete
  // point on, each cell takes its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (hit) begin
        data <= ctrl.value;
      end else if (above) begin
        data <= left_data;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        data <= right_data;
      end
    end
  end

  assign rd_data = hit ? data : '0;

endmodule

`default_nettype wire

// ----- dv/positional_insert_delete_list_top_tb.sv -----
`timescale 1ns / 1ps

module positional_insert_delete_list_top_tb;

  localparam int LIST_CAP = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 85;
  localparam int NUM_PHASES = 10;
  localparam logic [pidl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [pidl_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [pidl_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef enum int { GROW, SHRINK, MIXED } list_phase_t;

  typedef struct packed {
    logic                               ok;
    logic signed [pidl_pkg::DATA_W-1:0] read_value;
    logic [pidl_pkg::COUNT_W-1:0]       count;
  } list_result_t;

  typedef struct {
    logic [pidl_pkg::OP_W-1:0]          op;
    logic [pidl_pkg::LOC_W-1:0]         loc;
    logic signed [pidl_pkg::DATA_W-1:0] value;
    bit                                 pinned;
    list_result_t                       want;
  } cmd_row_t;

  logic                               clk;
  logic                               rst;
  logic                               start;
  logic                               busy;
  logic [pidl_pkg::OP_W-1:0]          op;
  logic [pidl_pkg::LOC_W-1:0]         location;
  logic signed [pidl_pkg::DATA_W-1:0] value;
  logic                               done;
  logic                               ok;
  logic signed [pidl_pkg::DATA_W-1:0] read_value;
  logic [pidl_pkg::COUNT_W-1:0]       count;

  // Shadow copy of the list, updated at each accepted transaction.
  logic signed [pidl_pkg::DATA_W-1:0] list_words [LIST_CAP];
  int                                 list_len;

  list_result_t pending_results [$];
  list_result_t oldest_result;
  int           mismatches;
  int           cycle_count;

  // Rows with pinned results can be worked out by hand; the others are
  // checked against the shadow list.
  cmd_row_t directed_rows [25] = '{
    '{pidl_pkg::OP_GET,    6'd0,  32'sd0,         1'b1, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_DELETE, 6'd0,  32'sd0,         1'b1, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_INSERT, 6'd1,  32'sd5,         1'b1, '{1'b0, 32'sd0,   7'd0}},
    '{OP_UNUSED,           6'd63, -32'sd1,        1'b1, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_INSERT, 6'd0,  WORD_MIN,       1'b1, '{1'b1, 32'sd0,   7'd1}},
    '{pidl_pkg::OP_INSERT, 6'd1,  WORD_MAX,       1'b1, '{1'b1, 32'sd0,   7'd2}},
    '{pidl_pkg::OP_GET,    6'd0,  32'sd0,         1'b1, '{1'b1, WORD_MIN, 7'd2}},
    '{pidl_pkg::OP_GET,    6'd1,  -32'sd1,        1'b1, '{1'b1, WORD_MAX, 7'd2}},
    '{pidl_pkg::OP_GET,    6'd2,  32'sd0,         1'b1, '{1'b0, 32'sd0,   7'd2}},
    '{pidl_pkg::OP_INSERT, 6'd0,  -32'sd1,        1'b1, '{1'b1, 32'sd0,   7'd3}},
    '{pidl_pkg::OP_INSERT, 6'd2,  32'sh1234_5678, 1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd0,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd1,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd2,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd3,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_INSERT, 6'd63, 32'sd7,         1'b1, '{1'b0, 32'sd0,   7'd4}},
    '{pidl_pkg::OP_GET,    6'd63, 32'sd0,         1'b1, '{1'b0, 32'sd0,   7'd4}},
    '{pidl_pkg::OP_DELETE, 6'd1,  WORD_MAX,       1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_DELETE, 6'd3,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd1,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_DELETE, 6'd0,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{OP_UNUSED,           6'd0,  WORD_MIN,       1'b1, '{1'b0, 32'sd0,   7'd2}},
    '{pidl_pkg::OP_DELETE, 6'd1,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_DELETE, 6'd0,  32'sd0,         1'b0, '{1'b0, 32'sd0,   7'd0}},
    '{pidl_pkg::OP_GET,    6'd0,  32'sd0,         1'b1, '{1'b0, 32'sd0,   7'd0}}
  };

  positional_insert_delete_list_top #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .location  (location),
    .value     (value),
    .done      (done),
    .ok        (ok),
    .read_value(read_value),
    .count     (count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(
    logic [pidl_pkg::OP_W-1:0] o, logic [pidl_pkg::LOC_W-1:0] loc,
    logic signed [pidl_pkg::DATA_W-1:0] val);
    list_result_t r;
    r = '0;
    case (o)
      pidl_pkg::OP_INSERT: begin
        if (loc <= list_len && list_len < LIST_CAP) begin
          for (int j = list_len; j > loc; j--) list_words[j] = list_words[j-1];
          list_words[loc] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      pidl_pkg::OP_GET: begin
        if (loc < list_len) begin
          r.ok = 1'b1;
          r.read_value = list_words[loc];
        end
      end
      pidl_pkg::OP_DELETE: begin
        if (loc < list_len) begin
          for (int j = loc; j + 1 < list_len; j++) list_words[j] = list_words[j+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = pidl_pkg::COUNT_W'(list_len);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Drives one transaction, after an idle gap if gap is nonzero, and waits for it to be taken.
  task automatic send_cmd(input logic [pidl_pkg::OP_W-1:0] o,
                          input logic [pidl_pkg::LOC_W-1:0] loc,
                          input logic signed [pidl_pkg::DATA_W-1:0] val, input int gap,
                          input bit pinned, input list_result_t want);
    list_result_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    op       <= o;
    location <= loc;
    value    <= val;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_list_op(o, loc, val);
    pending_results.push_back(pinned ? want : predicted);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The result is valid for exactly the cycle that ends at this edge.
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected done", done, 0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (ok !== oldest_result.ok) flag_mismatch("ok", ok, oldest_result.ok);
        if (read_value !== oldest_result.read_value)
          flag_mismatch("read_value", read_value, oldest_result.read_value);
        if (count !== oldest_result.count) flag_mismatch("count", count, oldest_result.count);
      end
    end
  end

  initial begin
    list_phase_t                        phase_kind [NUM_PHASES];
    list_phase_t                        kind;
    bit                                 no_gaps;
    int                                 pick;
    int                                 gap;
    logic [pidl_pkg::OP_W-1:0]          r_op;
    logic [pidl_pkg::LOC_W-1:0]         r_loc;
    logic signed [pidl_pkg::DATA_W-1:0] r_val;

    phase_kind = '{GROW, MIXED, SHRINK, GROW, MIXED, GROW, SHRINK, MIXED, GROW, SHRINK};
    mismatches  = 0;
    cycle_count = 0;
    list_len    = 0;
    rst      = 1'b1;
    start    = 1'b0;
    op       = pidl_pkg::OP_INSERT;
    location = '0;
    value    = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].op, directed_rows[i].loc, directed_rows[i].value,
               $urandom_range(0, 6), directed_rows[i].pinned, directed_rows[i].want);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      kind    = phase_kind[p];
      no_gaps = (p % 4 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          GROW:    r_op = pick < 85 ? pidl_pkg::OP_INSERT : pick < 92 ? pidl_pkg::OP_GET :
                          pick < 97 ? pidl_pkg::OP_DELETE : OP_UNUSED;
          SHRINK:  r_op = pick < 10 ? pidl_pkg::OP_INSERT : pick < 15 ? pidl_pkg::OP_GET :
                          pick < 95 ? pidl_pkg::OP_DELETE : OP_UNUSED;
          default: r_op = pick < 35 ? pidl_pkg::OP_INSERT : pick < 65 ? pidl_pkg::OP_GET :
                          pick < 95 ? pidl_pkg::OP_DELETE : OP_UNUSED;
        endcase

        // Mostly legal positions; the rest hit anywhere, including past the end.
        if ($urandom_range(0, 99) < 15)
          r_loc = pidl_pkg::LOC_W'($urandom_range(0, 63));
        else if (r_op == pidl_pkg::OP_INSERT)
          r_loc = pidl_pkg::LOC_W'($urandom_range(0, list_len > 63 ? 63 : list_len));
        else if (list_len == 0)
          r_loc = pidl_pkg::LOC_W'($urandom_range(0, 63));
        else
          r_loc = pidl_pkg::LOC_W'($urandom_range(0, list_len - 1));

        case ($urandom_range(0, 19))
          0:       r_val = WORD_MIN;
          1:       r_val = WORD_MAX;
          2:       r_val = -32'sd1;
          3:       r_val = 32'sd0;
          default: r_val = $urandom;
        endcase

        gap = no_gaps ? 0 : $urandom_range(0, 6);
        send_cmd(r_op, r_loc, r_val, gap, 1'b0, '0);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
